// ===== rtl/ogru_pkg.sv =====
// ----------------------------------------------------------------------------
// ogru_pkg
// Shared types and constants for the occupancy grid ray update block.
// ----------------------------------------------------------------------------
`default_nettype none

package ogru_pkg;

    // Default grid geometry.
    localparam int GRID_SIZE_DEF = 256;
    localparam int CELL_BITS_DEF = 16;

    // Fixed field widths of the command and result channels.
    localparam int COORD_W  = 8;
    localparam int VALUE_W  = 16;
    localparam int COUNT_W  = 9;
    localparam int CMD_W    = 2;
    localparam int FREE_W   = 8;
    localparam int HIT_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;

    // Register reset values.
    localparam logic [FREE_W-1:0] FREE_STEP_RST = 8'd1;
    localparam logic [HIT_W-1:0]  HIT_STEP_RST  = 10'd100;

    // Hit neighborhood: three rows by three columns.
    localparam logic [1:0]         HIT_SPAN_LAST = 2'd2;
    localparam logic [COUNT_W-1:0] HIT_CELLS     = 9'd9;

    // Longest ray that 8-bit coordinates can describe.
    localparam logic [COUNT_W-1:0] MAX_CELLS = 9'd256;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_RAY  = 2'd0,
        CMD_HIT  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NOP  = 2'd3
    } t_cmd;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_STEP  = 2'd1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture a new command
        logic clear_en;  // write zero at the clear pointer
        logic ray_en;    // process the current line cell
        logic hit_en;    // process the current neighborhood cell
        logic read_en;   // read the addressed cell
        logic publish;   // move the result into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;  // clear pointer at the last cell
        logic ray_end;     // line walker sits on the end cell
        logic hit_last;    // last neighborhood cell
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/ogru_ctrl.sv =====
// ----------------------------------------------------------------------------
// ogru_ctrl
// Controller state machine: clearing pass, command sequencing and the
// output valid register.
// ----------------------------------------------------------------------------
`default_nettype none

module ogru_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic [ogru_pkg::CMD_W-1:0] i_cmd,
    output logic                       o_in_stall,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output ogru_pkg::t_dp_cmd          o_dp_cmd,
    input  ogru_pkg::t_dp_status       i_dp_status
);
    import ogru_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RAY,
        S_HIT,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    logic   out_free;

    // Handshake terms.
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // Datapath commands decoded from the state.
    always_comb begin
        o_dp_cmd          = '0;
        o_dp_cmd.load     = accept;
        o_dp_cmd.clear_en = (r_state == S_CLEAR);
        o_dp_cmd.ray_en   = (r_state == S_RAY);
        o_dp_cmd.hit_en   = (r_state == S_HIT);
        o_dp_cmd.read_en  = (r_state == S_READ);
        o_dp_cmd.publish  = (r_state == S_DONE) && out_free;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_dp_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_cmd))
                        CMD_RAY:  n_state = S_RAY;
                        CMD_HIT:  n_state = S_HIT;
                        CMD_READ: n_state = S_READ;
                        CMD_NOP:  n_state = S_DRAIN;
                    endcase
                end
            end
            S_RAY: begin
                if (i_dp_status.ray_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_HIT: begin
                if (i_dp_status.hit_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_READ:  n_state = S_DRAIN;
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and output valid register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_dp_cmd.publish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // An accepted command always leaves the idle state.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("accepted command did not start");

    // No result is offered while the grid is being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result offered during clearing pass");

    // A new result appears only out of the done state.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result raised outside done state");

endmodule

`default_nettype wire

// ===== rtl/ogru_dp.sv =====
// ----------------------------------------------------------------------------
// ogru_dp
// Datapath: configuration registers, grid memory with a read-modify-write
// pipeline, line walker, neighborhood counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ogru_dp #(
    parameter int GRID_SIZE = ogru_pkg::GRID_SIZE_DEF,
    parameter int CELL_BITS = ogru_pkg::CELL_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  ogru_pkg::t_dp_cmd                i_dp_cmd,
    output ogru_pkg::t_dp_status             o_dp_status,
    input  wire logic                        i_cfg_we,
    input  wire logic [ogru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [ogru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [ogru_pkg::COORD_W-1:0] i_start_row,
    input  wire logic [ogru_pkg::COORD_W-1:0] i_start_col,
    input  wire logic [ogru_pkg::COORD_W-1:0] i_end_row,
    input  wire logic [ogru_pkg::COORD_W-1:0] i_end_col,
    input  wire logic [ogru_pkg::COORD_W-1:0] i_skip_row,
    input  wire logic [ogru_pkg::COORD_W-1:0] i_skip_col,
    output logic signed [ogru_pkg::VALUE_W-1:0] o_cell_value,
    output logic [ogru_pkg::COUNT_W-1:0]     o_cells_written
);
    import ogru_pkg::*;

    localparam int DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(GRID_SIZE);
    localparam int CMPW  = (CW > COORD_W) ? CW : COORD_W;
    localparam int EW    = CW + 2;
    localparam int SW    = ((CELL_BITS > HIT_W + 1) ? CELL_BITS : HIT_W + 1) + 1;
    localparam int RW    = (CELL_BITS > VALUE_W) ? CELL_BITS : VALUE_W;

    // Clamp an 8-bit coordinate to the last row or column of the grid.
    function automatic logic [CW-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        logic [CMPW-1:0] w;
        w = CMPW'(v);
        if (w > CMPW'(GRID_SIZE - 1)) begin
            w = CMPW'(GRID_SIZE - 1);
        end
        return CW'(w);
    endfunction

    // Clamp a coordinate one cell inside the border.
    function automatic logic [CW-1:0] clamp_inner(input logic [CW-1:0] v);
        logic [CW-1:0] w;
        w = v;
        if (w < CW'(1)) begin
            w = CW'(1);
        end else if (w > CW'(GRID_SIZE - 2)) begin
            w = CW'(GRID_SIZE - 2);
        end
        return w;
    endfunction

    // Linear cell address.
    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] row,
                                                 input logic [CW-1:0] col);
        return AW'(AW'(row) * AW'(GRID_SIZE)) + AW'(col);
    endfunction

    // Configuration registers.
    logic [FREE_W-1:0] r_free_step;
    logic [HIT_W-1:0]  r_hit_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_step <= FREE_STEP_RST;
            r_hit_step  <= HIT_STEP_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_FREE_STEP) begin
                r_free_step <= i_cfg_data[FREE_W-1:0];
            end else if (i_cfg_index == CFG_HIT_STEP) begin
                r_hit_step <= i_cfg_data[HIT_W-1:0];
            end
        end
    end

    // Command capture with clamped coordinates.
    logic [CW-1:0] ld_r0, ld_c0, ld_r1, ld_c1;
    logic [CW-1:0] ld_dr, ld_dc;

    assign ld_r0 = clamp_coord(i_start_row);
    assign ld_c0 = clamp_coord(i_start_col);
    assign ld_r1 = clamp_coord(i_end_row);
    assign ld_c1 = clamp_coord(i_end_col);
    assign ld_dr = (ld_r1 >= ld_r0) ? (ld_r1 - ld_r0) : (ld_r0 - ld_r1);
    assign ld_dc = (ld_c1 >= ld_c0) ? (ld_c1 - ld_c0) : (ld_c0 - ld_c1);

    logic [CW-1:0]        r_row, r_col, r_end_row, r_end_col;
    logic [CW-1:0]        r_dr, r_dc;
    logic                 r_row_up, r_col_up;
    logic signed [EW-1:0] r_err;
    logic [COORD_W-1:0]   r_skip_row, r_skip_col;
    logic [CW-1:0]        r_hit_row, r_hit_col;
    logic [1:0]           r_hi, r_hj;

    // Line walker step terms.
    logic signed [EW:0]   e2, dr_x, dc_x;
    logic                 step_row, step_col;
    logic signed [EW-1:0] n_err;

    always_comb begin
        e2       = $signed({r_err, 1'b0});
        dr_x     = $signed((EW + 1)'(r_dr));
        dc_x     = $signed((EW + 1)'(r_dc));
        step_row = (e2 > -dc_x);
        step_col = (e2 < dr_x);
        n_err    = r_err;
        if (step_row) begin
            n_err = n_err - $signed(EW'(r_dc));
        end
        if (step_col) begin
            n_err = n_err + $signed(EW'(r_dr));
        end
    end

    // Command registers and the walkers.
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_row      <= ld_r0;
            r_col      <= ld_c0;
            r_end_row  <= ld_r1;
            r_end_col  <= ld_c1;
            r_dr       <= ld_dr;
            r_dc       <= ld_dc;
            r_row_up   <= (ld_r1 >= ld_r0);
            r_col_up   <= (ld_c1 >= ld_c0);
            r_err      <= $signed(EW'(ld_dr)) - $signed(EW'(ld_dc));
            r_skip_row <= i_skip_row;
            r_skip_col <= i_skip_col;
            r_hit_row  <= clamp_inner(ld_r1) - CW'(1);
            r_hit_col  <= clamp_inner(ld_c1) - CW'(1);
            r_hi       <= '0;
            r_hj       <= '0;
        end else begin
            if (i_dp_cmd.ray_en) begin
                r_err <= n_err;
                if (step_row) begin
                    r_row <= r_row_up ? r_row + CW'(1) : r_row - CW'(1);
                end
                if (step_col) begin
                    r_col <= r_col_up ? r_col + CW'(1) : r_col - CW'(1);
                end
            end
            if (i_dp_cmd.hit_en) begin
                if (r_hj == HIT_SPAN_LAST) begin
                    r_hj <= '0;
                    r_hi <= r_hi + 2'd1;
                end else begin
                    r_hj <= r_hj + 2'd1;
                end
            end
        end
    end

    // Clearing pointer.
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_dp_cmd.clear_en) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Status to the controller.
    always_comb begin
        o_dp_status            = '0;
        o_dp_status.clear_last = (r_clr_addr == AW'(DEPTH - 1));
        o_dp_status.ray_end    = (r_row == r_end_row) && (r_col == r_end_col);
        o_dp_status.hit_last   = (r_hi == HIT_SPAN_LAST) && (r_hj == HIT_SPAN_LAST);
    end

    // Read address and write decision of the first pipeline stage.
    logic [AW-1:0] rd_addr;
    logic          rd_en;
    logic          on_skip;
    logic          issue_wr;

    assign on_skip  = (CMPW'(r_row) == CMPW'(r_skip_row)) &&
                      (CMPW'(r_col) == CMPW'(r_skip_col));
    assign issue_wr = (i_dp_cmd.ray_en && !on_skip) || i_dp_cmd.hit_en;
    assign rd_en    = i_dp_cmd.ray_en || i_dp_cmd.hit_en || i_dp_cmd.read_en;

    always_comb begin
        if (i_dp_cmd.hit_en) begin
            rd_addr = cell_addr(r_hit_row + CW'(r_hi), r_hit_col + CW'(r_hj));
        end else if (i_dp_cmd.read_en) begin
            rd_addr = cell_addr(r_end_row, r_end_col);
        end else begin
            rd_addr = cell_addr(r_row, r_col);
        end
    end

    // Pipeline registers between the read and the write stage.
    logic          r_wr_pend;
    logic          r_wr_neg;
    logic          r_rd_capture;
    logic [AW-1:0] r_wr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend    <= 1'b0;
            r_rd_capture <= 1'b0;
        end else begin
            r_wr_pend    <= issue_wr;
            r_rd_capture <= i_dp_cmd.read_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= rd_addr;
        r_wr_neg  <= i_dp_cmd.ray_en;
    end

    // Saturating update of the cell read in the previous cycle.
    logic [CELL_BITS-1:0]    r_rd_data;
    logic signed [SW-1:0]    cell_ext, step_mag, upd_sum;
    logic [SW-CELL_BITS:0]   upd_hi;
    logic [CELL_BITS-1:0]    upd_val;

    always_comb begin
        cell_ext = SW'($signed(r_rd_data));
        step_mag = r_wr_neg ? $signed(SW'(r_free_step)) : $signed(SW'(r_hit_step));
        upd_sum  = r_wr_neg ? cell_ext - step_mag : cell_ext + step_mag;
        upd_hi   = upd_sum[SW-1:CELL_BITS-1];
        if ((&upd_hi) || !(|upd_hi)) begin
            upd_val = upd_sum[CELL_BITS-1:0];
        end else begin
            upd_val = {upd_sum[SW-1], {(CELL_BITS - 1){~upd_sum[SW-1]}}};
        end
    end

    // Grid memory: one write port, one registered read port.
    logic [CELL_BITS-1:0] r_mem [DEPTH];
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic [CELL_BITS-1:0] mem_wd;

    always_comb begin
        if (i_dp_cmd.clear_en) begin
            mem_we = 1'b1;
            mem_wa = r_clr_addr;
            mem_wd = '0;
        end else begin
            mem_we = r_wr_pend;
            mem_wa = r_wr_addr;
            mem_wd = upd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Read value saturated to the result width.
    logic signed [RW-1:0]   rd_ext;
    logic [RW-VALUE_W:0]    rd_hi;
    logic [VALUE_W-1:0]     rd_val;

    always_comb begin
        rd_ext = RW'($signed(r_rd_data));
        rd_hi  = rd_ext[RW-1:VALUE_W-1];
        if ((&rd_hi) || !(|rd_hi)) begin
            rd_val = rd_ext[VALUE_W-1:0];
        end else begin
            rd_val = {rd_ext[RW-1], {(VALUE_W - 1){~rd_ext[RW-1]}}};
        end
    end

    // Per-command result and the output register.
    logic [COUNT_W-1:0]        r_count;
    logic signed [VALUE_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.load) begin
            r_count <= '0;
            r_value <= '0;
        end else begin
            if (issue_wr) begin
                r_count <= r_count + COUNT_W'(1);
            end
            if (r_rd_capture) begin
                r_value <= $signed(rd_val);
            end
        end
        if (i_dp_cmd.publish) begin
            o_cell_value    <= r_value;
            o_cells_written <= r_count;
        end
    end

    // The write of one cell never collides with the read of the next.
    a_no_rmw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pend && rd_en) |-> (r_wr_addr != rd_addr))
        else $error("read and write of the same cell in one cycle");

    // A finished neighborhood update has counted nine cells.
    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_dp_cmd.hit_en && o_dp_status.hit_last) |=> (r_count == HIT_CELLS))
        else $error("hit did not write nine cells");

    // No command writes more cells than the longest line.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_dp_cmd.publish |-> (r_count <= MAX_CELLS))
        else $error("cell count out of range");

endmodule

`default_nettype wire

// ===== rtl/occupancy_grid_ray_update.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_ray_update
// Square occupancy grid of saturating signed counts with ray, hit and read
// commands.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on i_in_valid / o_in_stall; one transfer carries a command
//   and its coordinates. Every command returns exactly one result on
//   o_out_valid / i_out_stall. The configuration channel (i_cfg_valid /
//   o_cfg_ready) sets free_step (index 0) and hit_step (index 1); write it
//   only while no command is in flight.
//   Timing: one command at a time. A ray walks the N cells of its line (up to
//   256), a hit the nine cells of its neighborhood and a read one cell. The
//   next command can be taken in the same cycle as the earliest result
//   transfer. Each cell costs one access of the grid memory's read port; the
//   write of one cell overlaps the read of the next.
//   Reset: the grid memory is swept to zero, one cell a cycle, over all
//   GRID_SIZE * GRID_SIZE cells (65536 by default); o_in_stall stays high
//   during the sweep.
//   A stalled result is held in the output register; the next command is
//   taken meanwhile and waits for the register before its result is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module occupancy_grid_ray_update #(
    parameter int GRID_SIZE = ogru_pkg::GRID_SIZE_DEF,
    parameter int CELL_BITS = ogru_pkg::CELL_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Command channel.
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic [ogru_pkg::CMD_W-1:0]       i_cmd,
    input  wire logic [ogru_pkg::COORD_W-1:0]     i_start_row,
    input  wire logic [ogru_pkg::COORD_W-1:0]     i_start_col,
    input  wire logic [ogru_pkg::COORD_W-1:0]     i_end_row,
    input  wire logic [ogru_pkg::COORD_W-1:0]     i_end_col,
    input  wire logic [ogru_pkg::COORD_W-1:0]     i_skip_row,
    input  wire logic [ogru_pkg::COORD_W-1:0]     i_skip_col,
    // Result channel.
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic signed [ogru_pkg::VALUE_W-1:0]   o_cell_value,
    output logic [ogru_pkg::COUNT_W-1:0]          o_cells_written,
    // Configuration channel.
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [ogru_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [ogru_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ogru_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cfg_we;

    // Registers can always take a write.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // Controller.
    ogru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cmd       (i_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dp_cmd    (dp_cmd),
        .i_dp_status (dp_status)
    );

    // Datapath with the grid memory.
    ogru_dp #(
        .GRID_SIZE (GRID_SIZE),
        .CELL_BITS (CELL_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_dp_cmd        (dp_cmd),
        .o_dp_status     (dp_status),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_start_row     (i_start_row),
        .i_start_col     (i_start_col),
        .i_end_row       (i_end_row),
        .i_end_col       (i_end_col),
        .i_skip_row      (i_skip_row),
        .i_skip_col      (i_skip_col),
        .o_cell_value    (o_cell_value),
        .o_cells_written (o_cells_written)
    );

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the occupancy grid ray update block. It keeps its
// own copy of the grid and both step registers, predicts the result of every
// command at the moment its transfer is taken, and compares each result
// transfer with the oldest prediction. Short directed commands cover the
// border, the line octants and the skip cell. Several random phases follow,
// each under a different pair of step values, most with random gaps and stalls.
// ----------------------------------------------------------------------------
module testbench;
    import ogru_pkg::*;

    localparam int GRID_SIDE = GRID_SIZE_DEF;
    localparam int LAST_IDX = GRID_SIDE - 1;
    localparam int CELL_HI = 2 ** (VALUE_W - 1) - 1;
    localparam int CELL_LO = -(2 ** (VALUE_W - 1));
    localparam int CLK_HALF = 6;
    localparam int RST_CYCLES = 6;
    // Longest ray plus handshake overhead.
    localparam int TAIL_CYCLES = 300;
    // Far beyond the reset sweep plus every command at its slowest.
    localparam longint RUN_LIMIT_NS = 60_000_000;

    // One command as it crosses the command channel.
    typedef struct packed {
        t_cmd               cmd;
        logic [COORD_W-1:0] start_row;
        logic [COORD_W-1:0] start_col;
        logic [COORD_W-1:0] end_row;
        logic [COORD_W-1:0] end_col;
        logic [COORD_W-1:0] skip_row;
        logic [COORD_W-1:0] skip_col;
    } t_grid_cmd;

    // One result as it crosses the result channel.
    typedef struct packed {
        logic signed [VALUE_W-1:0] cell_value;
        logic [COUNT_W-1:0]        cells_written;
    } t_grid_result;

    // Shape of the random commands in one phase.
    typedef struct {
        int unsigned n_items;
        int unsigned ray_pct;
        int unsigned hit_pct;
        int unsigned read_pct;
        int unsigned span;
        int unsigned spread_pct;
        int unsigned skip_pct;
        int unsigned base_row;
        int unsigned base_col;
        bit          calm;
    } t_phase_plan;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    t_cmd                       i_cmd = CMD_NOP;
    logic [COORD_W-1:0]         i_start_row = '0;
    logic [COORD_W-1:0]         i_start_col = '0;
    logic [COORD_W-1:0]         i_end_row = '0;
    logic [COORD_W-1:0]         i_end_col = '0;
    logic [COORD_W-1:0]         i_skip_row = '0;
    logic [COORD_W-1:0]         i_skip_col = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [VALUE_W-1:0]  o_cell_value;
    logic [COUNT_W-1:0]         o_cells_written;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    // Predicted grid and step registers.
    logic signed [VALUE_W-1:0]  grid_model [GRID_SIDE * GRID_SIDE];
    logic [FREE_W-1:0]          free_step_model = FREE_STEP_RST;
    logic [HIT_W-1:0]           hit_step_model = HIT_STEP_RST;

    t_grid_cmd                  pending_cmds [$];
    t_grid_result               awaited_results [$];
    t_grid_cmd                  on_port;
    t_grid_result               oldest;
    int unsigned                queued_total = 0;
    int unsigned                accepted_total = 0;
    int unsigned                fail_count = 0;
    int unsigned                send_gap = 0;
    int unsigned                send_calm = 0;
    int unsigned                hold_gap = 0;
    int unsigned                hold_calm = 0;
    bit                         calm_phase = 1'b0;

    occupancy_grid_ray_update dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_start_row     (i_start_row),
        .i_start_col     (i_start_col),
        .i_end_row       (i_end_row),
        .i_end_col       (i_end_col),
        .i_skip_row      (i_skip_row),
        .i_skip_col      (i_skip_col),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_value    (o_cell_value),
        .o_cells_written (o_cells_written),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Add a signed step to one cell, saturating at the cell limits.
    function automatic void bump_cell(int row, int col, int delta);
        int idx;
        int sum;
        idx = row * GRID_SIDE + col;
        sum = int'(grid_model[idx]) + delta;
        if (sum > CELL_HI) sum = CELL_HI;
        else if (sum < CELL_LO) sum = CELL_LO;
        grid_model[idx] = sum[VALUE_W-1:0];
    endfunction

    // Update the predicted grid with one command and return its result.
    function automatic t_grid_result apply_command(t_grid_cmd c);
        t_grid_result res;
        int row, col, row_to, col_to;
        int d_row, d_col, row_dir, col_dir, err, err2;
        int ctr_row, ctr_col;
        int unsigned touched;
        res = '0;
        touched = 0;
        row_to = c.end_row;
        col_to = c.end_col;
        case (c.cmd)
            CMD_RAY: begin
                row = c.start_row;
                col = c.start_col;
                d_row = (row_to > row) ? row_to - row : row - row_to;
                d_col = (col_to > col) ? col_to - col : col - col_to;
                row_dir = (row_to >= row) ? 1 : -1;
                col_dir = (col_to >= col) ? 1 : -1;
                err = d_row - d_col;
                // Walk the line; both end cells are on it.
                while (1'b1) begin
                    if (row != int'(c.skip_row) || col != int'(c.skip_col)) begin
                        bump_cell(row, col, -int'(free_step_model));
                        touched++;
                    end
                    if (row == row_to && col == col_to) break;
                    err2 = 2 * err;
                    if (err2 > -d_col) begin
                        err -= d_col;
                        row += row_dir;
                    end
                    if (err2 < d_row) begin
                        err += d_row;
                        col += col_dir;
                    end
                end
            end
            CMD_HIT: begin
                // Keep the whole neighborhood inside the grid.
                ctr_row = (row_to < 1) ? 1 : ((row_to > LAST_IDX - 1) ? LAST_IDX - 1 : row_to);
                ctr_col = (col_to < 1) ? 1 : ((col_to > LAST_IDX - 1) ? LAST_IDX - 1 : col_to);
                for (int i = -1; i <= 1; i++) begin
                    for (int j = -1; j <= 1; j++) begin
                        bump_cell(ctr_row + i, ctr_col + j, int'(hit_step_model));
                    end
                end
                touched = 9;
            end
            CMD_READ: begin
                res.cell_value = grid_model[row_to * GRID_SIDE + col_to];
            end
            default: begin
            end
        endcase
        res.cells_written = touched[COUNT_W-1:0];
        return res;
    endfunction

    // Idle length for either side: mostly none or short, rarely long, with
    // occasional stretches of no idling at all.
    function automatic int unsigned next_idle(inout int unsigned calm_left);
        int unsigned roll;
        if (calm_phase) return 0;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [COORD_W-1:0] coord_in(int unsigned base, int unsigned span,
                                                    bit wide);
        if (wide) return COORD_W'($urandom_range(0, LAST_IDX));
        return COORD_W'(base + $urandom_range(0, span - 1));
    endfunction

    // Random command, mostly inside the phase window so that cells pile up.
    function automatic t_grid_cmd random_cmd(t_phase_plan p);
        t_grid_cmd c;
        int unsigned roll;
        bit wide;
        wide = ($urandom_range(0, 99) < p.spread_pct);
        c.start_row = coord_in(p.base_row, p.span, wide);
        c.start_col = coord_in(p.base_col, p.span, wide);
        c.end_row = coord_in(p.base_row, p.span, wide);
        c.end_col = coord_in(p.base_col, p.span, wide);
        roll = $urandom_range(0, 99);
        if (roll < p.ray_pct) c.cmd = CMD_RAY;
        else if (roll < p.ray_pct + p.hit_pct) c.cmd = CMD_HIT;
        else if (roll < p.ray_pct + p.hit_pct + p.read_pct) c.cmd = CMD_READ;
        else c.cmd = CMD_NOP;
        // Skip cell: the start, the end, the midpoint, or anywhere.
        roll = $urandom_range(0, 299);
        if (roll < p.skip_pct) begin
            c.skip_row = c.start_row;
            c.skip_col = c.start_col;
        end else if (roll < 2 * p.skip_pct) begin
            c.skip_row = c.end_row;
            c.skip_col = c.end_col;
        end else if (roll < 3 * p.skip_pct) begin
            c.skip_row = COORD_W'((int'(c.start_row) + int'(c.end_row)) / 2);
            c.skip_col = COORD_W'((int'(c.start_col) + int'(c.end_col)) / 2);
        end else begin
            c.skip_row = COORD_W'($urandom_range(0, LAST_IDX));
            c.skip_col = COORD_W'($urandom_range(0, LAST_IDX));
        end
        return c;
    endfunction

    function automatic void queue_cmd(t_grid_cmd c);
        pending_cmds = {pending_cmds, c};
        queued_total++;
    endfunction

    task automatic queue_directed(t_cmd k, int sr, int sc, int er, int ec, int kr, int kc);
        t_grid_cmd c;
        c.cmd = k;
        c.start_row = COORD_W'(sr);
        c.start_col = COORD_W'(sc);
        c.end_row = COORD_W'(er);
        c.end_col = COORD_W'(ec);
        c.skip_row = COORD_W'(kr);
        c.skip_col = COORD_W'(kc);
        queue_cmd(c);
    endtask

    // Wait until every queued command is taken and every result is back.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (accepted_total != queued_total || awaited_results.size() != 0);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_FREE_STEP) free_step_model = data[FREE_W-1:0];
        else if (idx == CFG_HIT_STEP) hit_step_model = data[HIT_W-1:0];
    endtask

    task automatic run_phase(t_phase_plan p);
        calm_phase = p.calm;
        repeat (p.n_items) queue_cmd(random_cmd(p));
        wait_drained();
    endtask

    // Clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run limit.
    initial begin
        #RUN_LIMIT_NS;
        $display("CHECK FAILED");
        $finish;
    end

    // Command driver: predicts each command when its transfer happens.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                awaited_results = {awaited_results, apply_command(on_port)};
                accepted_total++;
            end
            // A stalled command stays on the port unchanged.
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    on_port = pending_cmds.pop_front();
                    i_cmd <= on_port.cmd;
                    i_start_row <= on_port.start_row;
                    i_start_col <= on_port.start_col;
                    i_end_row <= on_port.end_row;
                    i_end_col <= on_port.end_col;
                    i_skip_row <= on_port.skip_row;
                    i_skip_col <= on_port.skip_col;
                    i_in_valid <= 1'b1;
                    send_gap = next_idle(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer and stalls the channel at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result, cell_value %0d cells_written %0d",
                             $time, o_cell_value, o_cells_written);
                    fail_count++;
                end else begin
                    oldest = awaited_results.pop_front();
                    if (o_cell_value !== oldest.cell_value) begin
                        $display("%0t: cell_value expected %0d actual %0d",
                                 $time, oldest.cell_value, o_cell_value);
                        fail_count++;
                    end
                    if (o_cells_written !== oldest.cells_written) begin
                        $display("%0t: cells_written expected %0d actual %0d",
                                 $time, oldest.cells_written, o_cells_written);
                        fail_count++;
                    end
                end
                hold_gap = next_idle(hold_calm);
            end
            if (hold_gap > 0) begin
                hold_gap--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Stimulus sequence.
    initial begin
        foreach (grid_model[k]) grid_model[k] = '0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands under the reset step values.
        queue_directed(CMD_READ, 0, 0, 0, 0, 0, 0);
        queue_directed(CMD_READ, 0, 0, 255, 255, 0, 0);
        queue_directed(CMD_HIT, 0, 0, 0, 0, 0, 0);
        queue_directed(CMD_READ, 0, 0, 0, 0, 0, 0);
        queue_directed(CMD_HIT, 0, 0, 255, 255, 0, 0);
        queue_directed(CMD_READ, 0, 0, 255, 255, 0, 0);
        queue_directed(CMD_HIT, 0, 0, 0, 255, 0, 0);
        queue_directed(CMD_HIT, 0, 0, 255, 0, 0, 0);
        queue_directed(CMD_READ, 0, 0, 255, 0, 0, 0);
        // Diagonals, straight lines and steep or shallow lines both ways.
        queue_directed(CMD_RAY, 0, 0, 255, 255, 128, 128);
        queue_directed(CMD_RAY, 255, 0, 0, 255, 0, 0);
        queue_directed(CMD_RAY, 0, 0, 0, 255, 0, 0);
        queue_directed(CMD_RAY, 255, 255, 255, 0, 255, 0);
        queue_directed(CMD_RAY, 0, 5, 255, 9, 7, 7);
        queue_directed(CMD_RAY, 100, 250, 97, 3, 255, 255);
        queue_directed(CMD_RAY, 200, 30, 20, 60, 110, 45);
        // Single-cell rays with and without the skip cell on them.
        queue_directed(CMD_RAY, 5, 5, 5, 5, 5, 5);
        queue_directed(CMD_RAY, 5, 5, 5, 5, 6, 6);
        queue_directed(CMD_READ, 0, 0, 5, 5, 0, 0);
        queue_directed(CMD_READ, 0, 0, 128, 128, 0, 0);
        queue_directed(CMD_READ, 0, 0, 0, 0, 0, 0);
        queue_directed(CMD_NOP, 255, 255, 255, 255, 255, 255);
        queue_directed(CMD_NOP, 0, 0, 0, 0, 0, 0);
        run_phase('{n_items: 250, ray_pct: 45, hit_pct: 25, read_pct: 25, span: 8,
                    spread_pct: 20, skip_pct: 40, base_row: $urandom_range(0, 248),
                    base_col: $urandom_range(0, 248), calm: 1'b0});

        // Largest steps in a 2x2 corner window: cells pin at the top limit.
        write_register(CFG_FREE_STEP, 10'd255);
        write_register(CFG_HIT_STEP, 10'd1023);
        run_phase('{n_items: 350, ray_pct: 40, hit_pct: 30, read_pct: 25, span: 2,
                    spread_pct: 5, skip_pct: 30, base_row: 254, base_col: 0, calm: 1'b0});

        // No hit gain and one hammered cell: it pins at the bottom limit.
        write_register(CFG_HIT_STEP, 10'd0);
        run_phase('{n_items: 300, ray_pct: 80, hit_pct: 5, read_pct: 12, span: 1,
                    spread_pct: 0, skip_pct: 10, base_row: $urandom_range(0, 255),
                    base_col: $urandom_range(0, 255), calm: 1'b0});

        // Zero free step, smallest hit step, both channels kept busy.
        write_register(CFG_FREE_STEP, 10'd0);
        write_register(CFG_HIT_STEP, 10'd1);
        run_phase('{n_items: 200, ray_pct: 40, hit_pct: 30, read_pct: 25, span: 16,
                    spread_pct: 10, skip_pct: 40, base_row: 0, base_col: 240, calm: 1'b1});

        // Random steps, wide coordinates.
        write_register(CFG_FREE_STEP, CFG_DATA_W'($urandom_range(1, 254)));
        write_register(CFG_HIT_STEP, CFG_DATA_W'($urandom_range(1, 1022)));
        run_phase('{n_items: 400, ray_pct: 45, hit_pct: 20, read_pct: 30, span: 32,
                    spread_pct: 50, skip_pct: 40, base_row: $urandom_range(0, 224),
                    base_col: $urandom_range(0, 224), calm: 1'b0});

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/ogru_pkg.sv
rtl/ogru_ctrl.sv
rtl/ogru_dp.sv
rtl/occupancy_grid_ray_update.sv
bench/testbench.sv
